### src/vssr_pkg.sv
// package: payload structs, register indexes, step modes and fixed widths
`default_nettype none

package vssr_pkg;

    localparam int FIELD_W     = 32;
    localparam int WANTED_W    = 29;
    localparam int STEP_W      = 29;
    localparam int TOL_W       = 16;
    localparam int CFG_DATA_W  = 29;
    localparam int CFG_INDEX_W = 2;
    localparam int FRAC_BITS   = 28;

    localparam logic [WANTED_W-1:0] WANTED_RESET = 29'd1610613;
    localparam logic [STEP_W-1:0]   STEP_RESET   = 29'd268435456;
    localparam logic [TOL_W-1:0]    TOL_RESET    = 16'd27;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WANTED_SPEED = 2'd0,
        REG_TIME_STEP    = 2'd1,
        REG_SPEED_TOL    = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_COAST  = 2'd0,
        MODE_ADJUST = 2'd1,
        MODE_KICK   = 2'd2
    } step_mode_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] cur_x;
        logic signed [FIELD_W-1:0] cur_y;
        logic signed [FIELD_W-1:0] cur_z;
        logic signed [FIELD_W-1:0] prev_x;
        logic signed [FIELD_W-1:0] prev_y;
        logic signed [FIELD_W-1:0] prev_z;
    } item_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] next_x;
        logic signed [FIELD_W-1:0] next_y;
        logic signed [FIELD_W-1:0] next_z;
        logic [1:0]                step_mode;
        logic                      saturated;
    } result_t;

endpackage

`default_nettype wire

### src/verlet_step_speed_regulated_unit.sv
// top level: pipelined position-verlet step with speed regulation
`default_nettype none

// usage
//   start/item: one particle transaction (current and previous position) is taken
//   at every rising edge where start is high; busy is always low, so a particle
//   may be offered in every cycle
//   done/result: next position, step mode and clamp flag, shown for one cycle;
//   the receiver cannot hold results off and the pipeline never stalls
//   cfg_write/cfg_index/cfg_data: register write, effective at the clock edge;
//   change registers only while no transaction is in flight
// pipeline
//   an accepted particle passes the input, square and sum registers, the
//   SQ = COORD_WIDTH+2 root stages, the decision, multiply and dividend registers,
//   the QW = max(COORD_WIDTH+2, 29)+1 divide stages, then rounding and output;
//   throughput one particle per clock, set by the bit-per-stage square root and divider
// reset
//   rst_n clears all stage valid bits and loads the register defaults; items
//   in flight are dropped

module verlet_step_speed_regulated_unit #(
    parameter int COORD_WIDTH = 32
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    start,
    output logic                                   busy,
    input  vssr_pkg::item_t                        item,
    output logic                                   done,
    output vssr_pkg::result_t                      result,
    input  wire                                    cfg_write,
    input  wire [vssr_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  wire [vssr_pkg::CFG_DATA_W-1:0]         cfg_data
);

    import vssr_pkg::*;

    // effective coordinate width and derived datapath widths
    localparam int CWE = (COORD_WIDTH < 16) ? 16 : ((COORD_WIDTH > 32) ? 32 : COORD_WIDTH);
    localparam int MW  = CWE + 1;                       // velocity and magnitudes
    localparam int SW  = 2 * MW + 2;                    // sum of squares
    localparam int SQ  = MW + 1;                        // root width, one stage per bit
    localparam int EW  = (SQ > WANTED_W) ? SQ : WANTED_W; // speed error
    localparam int AW  = EW + STEP_W;                   // scaled correction
    localparam int QW  = AW - FRAC_BITS;                // quotient bits, one stage each
    localparam int PLO = 32;                            // low slice of the split multiply
    localparam int PHI = AW - PLO;
    localparam int NW  = AW + MW;                       // dividend
    localparam int DW  = SQ + FRAC_BITS;                // divisor
    localparam int RW  = DW + 1;                        // partial remainder
    localparam int FW  = QW + 3;                        // final unsaturated sum

    // stage numbering
    localparam int ST_SQ0 = 3;
    localparam int ST_P   = ST_SQ0 + SQ;
    localparam int ST_M1  = ST_P + 1;
    localparam int ST_M2  = ST_P + 2;
    localparam int ST_R   = ST_M2 + QW + 1;
    localparam int ST_F   = ST_R + 1;
    localparam int DEPTH  = ST_F + 1;
    localparam int TAIL   = ST_R - ST_P + 1;

    localparam logic signed [FW-1:0] SAT_HI = (FW'(1) <<< (CWE - 1)) - FW'(1);
    localparam logic signed [FW-1:0] SAT_LO = -SAT_HI - FW'(1);

    // configuration registers
    logic [WANTED_W-1:0] wanted_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [TOL_W-1:0]    tol_reg;

    // valid bits and the position/velocity line that follows the item
    logic                vld_reg [DEPTH];
    logic [2:0][CWE-1:0] dl_c_reg [ST_R+1];
    logic [2:0][MW-1:0]  dl_v_reg [ST_R+1];

    // per-item control from the decision stage onward
    logic [1:0]          tl_mode_reg [TAIL];
    logic                tl_up_reg   [TAIL];
    logic [SQ-1:0]       tl_den_reg  [TAIL];

    // squares and sums
    logic [2*MW-1:0]     sq_v_reg [3];
    logic [2*MW-1:0]     sq_c_reg [3];
    logic [2*MW-1:0]     sq_v_next [3];
    logic [2*MW-1:0]     sq_c_next [3];
    logic [SW-1:0]       sum_v_reg;
    logic [SW-1:0]       sum_c_reg;

    // square root stages
    logic [SW-1:0]       sqv_rem_reg  [SQ];
    logic [SQ-1:0]       sqv_root_reg [SQ];
    logic [SW-1:0]       sqc_rem_reg  [SQ];
    logic [SQ-1:0]       sqc_root_reg [SQ];
    logic [SW-1:0]       sqv_rem_next  [SQ];
    logic [SQ-1:0]       sqv_root_next [SQ];
    logic [SW-1:0]       sqc_rem_next  [SQ];
    logic [SQ-1:0]       sqc_root_next [SQ];

    // decision stage
    logic [AW-1:0]       p_a_reg;
    logic [AW-1:0]       p_a_next;
    logic [1:0]          p_mode_next;
    logic                p_up_next;
    logic [SQ-1:0]       p_den_next;

    // split multiply
    logic [PLO+MW-1:0]   pl_reg [3];
    logic [PHI+MW-1:0]   ph_reg [3];
    logic [PLO+MW-1:0]   pl_next [3];
    logic [PHI+MW-1:0]   ph_next [3];

    // divider stages, index 0 holds the assembled dividend
    logic [RW-1:0]       dv_rem_reg [QW+1][3];
    logic [QW-1:0]       dv_low_reg [QW+1][3];
    logic [QW-1:0]       dv_q_reg   [QW+1][3];
    logic [RW-1:0]       dv_rem_next [QW+1][3];
    logic [QW-1:0]       dv_low_next [QW+1][3];
    logic [QW-1:0]       dv_q_next   [QW+1][3];

    // rounding and sign
    logic [QW+1:0]       d_reg  [3];
    logic [QW+1:0]       d_next [3];

    // output
    result_t             out_reg;
    result_t             out_next;

    assign busy   = 1'b0;
    assign done   = vld_reg[ST_F];
    assign result = out_reg;

    // register writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_reg <= WANTED_RESET;
            step_reg   <= STEP_RESET;
            tol_reg    <= TOL_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WANTED_SPEED: wanted_reg <= cfg_data[WANTED_W-1:0];
                REG_TIME_STEP:    step_reg   <= cfg_data[STEP_W-1:0];
                REG_SPEED_TOL:    tol_reg    <= cfg_data[TOL_W-1:0];
                default:          ;
            endcase
        end
    end

    // valid line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= start & ~busy;
            for (int k = 1; k < DEPTH; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // stages 1 and 2: magnitudes squared, then summed
    always_comb
    begin
        logic [MW-1:0] cx;
        logic [MW-1:0] vm;
        logic [MW-1:0] cm;
        for (int i = 0; i < 3; i++)
        begin
            cx = {dl_c_reg[0][i][CWE-1], dl_c_reg[0][i]};
            vm = dl_v_reg[0][i][MW-1] ? MW'(~dl_v_reg[0][i] + MW'(1)) : dl_v_reg[0][i];
            cm = cx[MW-1] ? MW'(~cx + MW'(1)) : cx;
            sq_v_next[i] = (2*MW)'(vm) * (2*MW)'(vm);
            sq_c_next[i] = (2*MW)'(cm) * (2*MW)'(cm);
        end
    end

    // square roots of both sums, one result bit per stage
    always_comb
    begin
        logic [SW-1:0] v_rem;
        logic [SW-1:0] c_rem;
        logic [SQ-1:0] v_root;
        logic [SQ-1:0] c_root;
        logic [SW-1:0] v_trial;
        logic [SW-1:0] c_trial;
        for (int j = 0; j < SQ; j++)
        begin
            if (j == 0)
            begin
                v_rem  = sum_v_reg;
                c_rem  = sum_c_reg;
                v_root = '0;
                c_root = '0;
            end
            else
            begin
                v_rem  = sqv_rem_reg[(j > 0) ? j - 1 : 0];
                c_rem  = sqc_rem_reg[(j > 0) ? j - 1 : 0];
                v_root = sqv_root_reg[(j > 0) ? j - 1 : 0];
                c_root = sqc_root_reg[(j > 0) ? j - 1 : 0];
            end
            v_trial = (SW'(v_root) << (SQ - j)) | (SW'(1) << (2 * (SQ - 1 - j)));
            c_trial = (SW'(c_root) << (SQ - j)) | (SW'(1) << (2 * (SQ - 1 - j)));
            if (v_rem >= v_trial)
            begin
                sqv_rem_next[j]  = v_rem - v_trial;
                sqv_root_next[j] = v_root | (SQ'(1) << (SQ - 1 - j));
            end
            else
            begin
                sqv_rem_next[j]  = v_rem;
                sqv_root_next[j] = v_root;
            end
            if (c_rem >= c_trial)
            begin
                sqc_rem_next[j]  = c_rem - c_trial;
                sqc_root_next[j] = c_root | (SQ'(1) << (SQ - 1 - j));
            end
            else
            begin
                sqc_rem_next[j]  = c_rem;
                sqc_root_next[j] = c_root;
            end
        end
    end

    // decision: coast, adjust along the velocity, or kick toward the origin
    always_comb
    begin
        logic [SQ-1:0] speed;
        logic [EW-1:0] ws;
        logic [EW-1:0] sp;
        logic [EW-1:0] err;
        logic [AW-1:0] a_adj;
        logic [AW-1:0] a_kick;
        logic          vzero;
        speed  = sqv_root_reg[SQ-1];
        ws     = EW'(wanted_reg);
        sp     = EW'(speed);
        err    = (ws > sp) ? ws - sp : sp - ws;
        vzero  = (dl_v_reg[ST_P-1] == '0);
        a_adj  = AW'(err) * AW'(step_reg);
        a_kick = AW'(wanted_reg) * AW'(step_reg);
        p_up_next = ws > sp;
        if (err > EW'(tol_reg))
        begin
            p_mode_next = vzero ? MODE_KICK : MODE_ADJUST;
        end
        else
        begin
            p_mode_next = MODE_COAST;
        end
        p_a_next   = vzero ? a_kick : a_adj;
        p_den_next = vzero ? sqc_root_reg[SQ-1] : speed;
    end

    // split multiply of the scaled correction by each axis magnitude
    always_comb
    begin
        logic [MW-1:0] cx;
        logic [MW-1:0] vv;
        logic [MW-1:0] b;
        for (int i = 0; i < 3; i++)
        begin
            cx = {dl_c_reg[ST_P][i][CWE-1], dl_c_reg[ST_P][i]};
            vv = dl_v_reg[ST_P][i];
            if (tl_mode_reg[0] == MODE_KICK)
            begin
                b = cx[MW-1] ? MW'(~cx + MW'(1)) : cx;
            end
            else
            begin
                b = vv[MW-1] ? MW'(~vv + MW'(1)) : vv;
            end
            pl_next[i] = (PLO+MW)'(p_a_reg[PLO-1:0]) * (PLO+MW)'(b);
            ph_next[i] = (PHI+MW)'(p_a_reg[AW-1:PLO]) * (PHI+MW)'(b);
        end
    end

    // dividend assembly, then restoring division one quotient bit per stage
    always_comb
    begin
        logic [NW-1:0] n;
        logic [RW-1:0] r2;
        logic [RW-1:0] dd;
        for (int i = 0; i < 3; i++)
        begin
            n = NW'(pl_reg[i]) + (NW'(ph_reg[i]) << PLO);
            dv_rem_next[0][i] = RW'(n[NW-1:QW]);
            dv_low_next[0][i] = n[QW-1:0];
            dv_q_next[0][i]   = '0;
        end
        for (int j = 1; j <= QW; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dd = RW'({tl_den_reg[j+1], {FRAC_BITS{1'b0}}});
                r2 = {dv_rem_reg[j-1][i][DW-1:0], dv_low_reg[j-1][i][QW-1]};
                dv_low_next[j][i] = {dv_low_reg[j-1][i][QW-2:0], 1'b0};
                if (r2 >= dd)
                begin
                    dv_rem_next[j][i] = r2 - dd;
                    dv_q_next[j][i]   = {dv_q_reg[j-1][i][QW-2:0], 1'b1};
                end
                else
                begin
                    dv_rem_next[j][i] = r2;
                    dv_q_next[j][i]   = {dv_q_reg[j-1][i][QW-2:0], 1'b0};
                end
            end
        end
    end

    // round half up, zero when coasting or the divisor is zero, then apply the direction of the correction
    always_comb
    begin
        logic [RW-1:0] dd;
        logic [QW:0]   m;
        logic [MW-1:0] cx;
        logic [MW-1:0] vv;
        logic          neg;
        logic          pos;
        for (int i = 0; i < 3; i++)
        begin
            dd = RW'({tl_den_reg[QW+2], {FRAC_BITS{1'b0}}});
            m  = (QW+1)'(dv_q_reg[QW][i]);
            if ({dv_rem_reg[QW][i], 1'b0} >= {1'b0, dd})
            begin
                m = m + (QW+1)'(1);
            end
            if (tl_mode_reg[QW+2] == MODE_COAST || tl_den_reg[QW+2] == '0)
            begin
                m = '0;
            end
            cx  = {dl_c_reg[ST_R-1][i][CWE-1], dl_c_reg[ST_R-1][i]};
            vv  = dl_v_reg[ST_R-1][i];
            pos = !vv[MW-1] && (vv != '0);
            if (tl_mode_reg[QW+2] == MODE_KICK)
            begin
                neg = !cx[MW-1] && (cx != '0);
            end
            else
            begin
                neg = (tl_up_reg[QW+2] != pos);
            end
            d_next[i] = neg ? (QW+2)'(~{1'b0, m} + (QW+2)'(1)) : {1'b0, m};
        end
    end

    // final sum and clamp to the coordinate range
    always_comb
    begin
        logic signed [FW-1:0]  nx;
        logic [2:0][FIELD_W-1:0] oc;
        logic                  sat;
        sat = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            nx = FW'($signed(dl_c_reg[ST_R][i])) + FW'($signed(dl_v_reg[ST_R][i]))
                 + FW'($signed(d_reg[i]));
            if (nx > SAT_HI)
            begin
                nx  = SAT_HI;
                sat = 1'b1;
            end
            else if (nx < SAT_LO)
            begin
                nx  = SAT_LO;
                sat = 1'b1;
            end
            oc[i] = '0;
            oc[i][CWE-1:0] = nx[CWE-1:0];
        end
        out_next.next_x    = oc[0];
        out_next.next_y    = oc[1];
        out_next.next_z    = oc[2];
        out_next.step_mode = tl_mode_reg[TAIL-1];
        out_next.saturated = sat;
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            dl_c_reg[0][i] <= item[(5-i)*FIELD_W +: CWE];
            dl_v_reg[0][i] <= {item[(5-i)*FIELD_W + CWE - 1], item[(5-i)*FIELD_W +: CWE]}
                            - {item[(2-i)*FIELD_W + CWE - 1], item[(2-i)*FIELD_W +: CWE]};
        end
        for (int k = 1; k <= ST_R; k++)
        begin
            dl_c_reg[k] <= dl_c_reg[k-1];
            dl_v_reg[k] <= dl_v_reg[k-1];
        end
        sq_v_reg  <= sq_v_next;
        sq_c_reg  <= sq_c_next;
        sum_v_reg <= SW'(sq_v_reg[0]) + SW'(sq_v_reg[1]) + SW'(sq_v_reg[2]);
        sum_c_reg <= SW'(sq_c_reg[0]) + SW'(sq_c_reg[1]) + SW'(sq_c_reg[2]);
        sqv_rem_reg  <= sqv_rem_next;
        sqv_root_reg <= sqv_root_next;
        sqc_rem_reg  <= sqc_rem_next;
        sqc_root_reg <= sqc_root_next;
        p_a_reg        <= p_a_next;
        tl_mode_reg[0] <= p_mode_next;
        tl_up_reg[0]   <= p_up_next;
        tl_den_reg[0]  <= p_den_next;
        for (int t = 1; t < TAIL; t++)
        begin
            tl_mode_reg[t] <= tl_mode_reg[t-1];
            tl_up_reg[t]   <= tl_up_reg[t-1];
            tl_den_reg[t]  <= tl_den_reg[t-1];
        end
        pl_reg     <= pl_next;
        ph_reg     <= ph_next;
        dv_rem_reg <= dv_rem_next;
        dv_low_reg <= dv_low_next;
        dv_q_reg   <= dv_q_next;
        d_reg      <= d_next;
        out_reg    <= out_next;
    end

`ifndef ASSERT_OFF
    // every result traces back to a transaction exactly one latency earlier
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, DEPTH))
        else $error("result without a matching transaction");

    // step mode is one of the three defined modes
    a_mode: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.step_mode == MODE_COAST || result.step_mode == MODE_ADJUST
                  || result.step_mode == MODE_KICK))
        else $error("undefined step mode");

    // a coasting particle gets no correction
    a_coast: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[ST_R] && tl_mode_reg[TAIL-1] == MODE_COAST)
        |-> (d_reg[0] == '0 && d_reg[1] == '0 && d_reg[2] == '0))
        else $error("correction applied while coasting");
`endif

endmodule

`default_nettype wire
